FILE: sv/coin_change_way_counter_macros.svh
// Assertion macros shared by the checker file of the coin change block.
// Both macros sample on the rising edge of clk_i and are disabled in reset.
`ifndef COIN_CHANGE_WAY_COUNTER_MACROS_SVH
`define COIN_CHANGE_WAY_COUNTER_MACROS_SVH

`define CCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define CCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccw_pkg;

  localparam int MAX_AMOUNT  = 1023;
  localparam int NUM_COINS   = 8;
  localparam int COUNT_WIDTH = 64;

  localparam int COIN_REGS  = 8;
  localparam int COIN_W     = 10;
  localparam int TGT_W      = 10;
  localparam int OUT_W      = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int COIN_IDX_W = $clog2(COIN_REGS);
  localparam int AMT_W      = $clog2(MAX_AMOUNT + 1);
  localparam int CMP_W      = (AMT_W > COIN_W) ? AMT_W : COIN_W;
  localparam int MEM_DEPTH  = MAX_AMOUNT + 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [AMT_W-1:0]       amount_t;
  typedef logic [COIN_W-1:0]      coin_t;

  localparam count_t COUNT_MAX = '1;

  localparam coin_t COIN_RESET [COIN_REGS] = '{
    10'd1, 10'd2, 10'd5, 10'd10, 10'd25, 10'd50, 10'd100, 10'd200
  };

  // One amount traveling down the row of cells with its running count.
  typedef struct packed {
    logic    vld;
    logic    last;
    amount_t amt;
    count_t  cnt;
    logic    sat;
  } ccw_tok_t;

  function automatic amount_t clamp_amount(input logic [TGT_W-1:0] t);
    if (int'(t) > MAX_AMOUNT) begin
      return amount_t'(MAX_AMOUNT);
    end
    return amount_t'(t);
  endfunction

endpackage

`default_nettype wire

FILE: sv/coin_change_way_counter.sv
// Counts the unordered combinations of the configured coin denominations that
// sum to the requested amount, with counts clamped at the all-ones value and a
// flag raised when any contributing sum was clamped. An amount of zero returns
// a count of zero directly, without entering the cells. Any other amount is streamed
// as the values 0 up to the amount, one per cycle, through a row of eight
// cells, one per coin; each cell keeps its own table of counts in a memory with
// one write and one read port and adds the entry one denomination back. The next
// item is accepted once the result has moved to the output register. The user
// must write the coin registers through the write port only while no item is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module coin_change_way_counter import ccw_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COIN_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TGT_W-1:0]     target_amount_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [OUT_W-1:0]          way_count_o,
  output logic                      count_saturated_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FEED  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  coin_t    coin_q [COIN_REGS];
  ccw_tok_t tok [NUM_COINS+1];

  logic [1:0] state_q, state_d;
  amount_t    amt_q, amt_d;
  amount_t    tgt_q;
  amount_t    tgt_clamped;
  count_t     res_cnt_q;
  logic       res_sat_q;
  logic       out_vld_q;
  count_t     out_cnt_q;
  logic       out_sat_q;
  logic       start;
  logic       res_take;
  logic       out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COIN_REGS; i++) begin
        coin_q[i] <= COIN_RESET[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(COIN_REGS))) begin
      coin_q[cfg_idx_i[COIN_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  assign tgt_clamped = clamp_amount(target_amount_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign start       = in_valid_i && in_ready_o;
  assign res_take    = (state_q == ST_DRAIN) && tok[NUM_COINS].vld && tok[NUM_COINS].last;
  assign out_load    = (state_q == ST_HOLD) && (!out_vld_q || out_ready_i);

  always_comb begin
    tok[0]      = '0;
    tok[0].vld  = (state_q == ST_FEED);
    tok[0].last = (amt_q == tgt_q);
    tok[0].amt  = amt_q;
    tok[0].cnt  = (amt_q == '0) ? count_t'(1) : '0;
    tok[0].sat  = 1'b0;
  end

  for (genvar k = 0; k < NUM_COINS; k++) begin : g_cell
    ccw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .coin_i (coin_q[k]),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  always_comb begin
    state_d = state_q;
    amt_d   = amt_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          amt_d   = '0;
          state_d = (tgt_clamped == '0) ? ST_HOLD : ST_FEED;
        end
      end
      ST_FEED: begin
        amt_d = amt_q + amount_t'(1);
        if (amt_q == tgt_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_take) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      amt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      amt_q   <= amt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      tgt_q     <= tgt_clamped;
      res_cnt_q <= '0;
      res_sat_q <= 1'b0;
    end else if (res_take) begin
      res_cnt_q <= tok[NUM_COINS].cnt;
      res_sat_q <= tok[NUM_COINS].sat;
    end
    if (out_load) begin
      out_cnt_q <= res_cnt_q;
      out_sat_q <= res_sat_q;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign way_count_o       = OUT_W'(out_cnt_q);
  assign count_saturated_o = out_sat_q;

endmodule

`default_nettype wire

FILE: sv/ccw_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ccw_cell import ccw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire coin_t    coin_i,
  input  wire ccw_tok_t tok_i,
  output ccw_tok_t      tok_o
);

  logic [COUNT_WIDTH:0] mem_q [MEM_DEPTH];

  logic                 s1_vld_q;
  ccw_tok_t             s1_q;
  logic                 add_en_q;
  logic                 byp_sel_q;
  logic [COUNT_WIDTH:0] rd_q;
  logic [COUNT_WIDTH:0] byp_q;
  logic                 out_vld_q;
  ccw_tok_t             out_q;
  ccw_tok_t             out_d;

  logic [CMP_W-1:0]     amt_ext;
  logic [CMP_W-1:0]     coin_ext;
  logic [CMP_W-1:0]     diff;
  amount_t              rd_addr;
  logic                 add_en_d;
  logic                 byp_sel_d;

  logic [COUNT_WIDTH:0] addend;
  logic [COUNT_WIDTH:0] sum_ext;
  count_t               cnt_new;
  logic                 sat_new;

  assign amt_ext   = CMP_W'(tok_i.amt);
  assign coin_ext  = CMP_W'(coin_i);
  assign diff      = amt_ext - coin_ext;
  assign rd_addr   = diff[AMT_W-1:0];
  assign add_en_d  = (coin_i != '0) && (amt_ext >= coin_ext);
  // With a coin of one the entry needed is the one being written this cycle.
  assign byp_sel_d = (coin_i == coin_t'(1));

  always_comb begin
    addend = '0;
    if (add_en_q) begin
      addend = byp_sel_q ? byp_q : rd_q;
    end
    sum_ext = {1'b0, s1_q.cnt} + {1'b0, addend[COUNT_WIDTH-1:0]};
    cnt_new = sum_ext[COUNT_WIDTH] ? COUNT_MAX : sum_ext[COUNT_WIDTH-1:0];
    sat_new = s1_q.sat | addend[COUNT_WIDTH] | sum_ext[COUNT_WIDTH];
  end

  always_comb begin
    out_d     = s1_q;
    out_d.cnt = cnt_new;
    out_d.sat = sat_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= tok_i.vld;
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= tok_i;
    add_en_q  <= add_en_d;
    byp_sel_q <= byp_sel_d;
    if (tok_i.vld && add_en_d) begin
      rd_q <= mem_q[rd_addr];
    end
    if (s1_vld_q) begin
      mem_q[s1_q.amt] <= {sat_new, cnt_new};
      byp_q           <= {sat_new, cnt_new};
    end
    out_q     <= out_d;
  end

  always_comb begin
    tok_o     = out_q;
    tok_o.vld = out_vld_q;
  end

endmodule

`default_nettype wire

FILE: sv/ccw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "coin_change_way_counter_macros.svh"

module ccw_checker import ccw_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_we_i,
  input wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [COIN_W-1:0]    cfg_data_i,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [TGT_W-1:0]     target_amount_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [OUT_W-1:0]     way_count_o,
  input wire logic                 count_saturated_o
);

  `CCW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result item dropped while stalled")

  `CCW_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(way_count_o) && $stable(count_saturated_o), "stalled result item changed")

  `CCW_ASSERT_SAME(a_sat_clamped, out_valid_o && count_saturated_o, way_count_o == OUT_W'(COUNT_MAX), "saturated count is not clamped")

  `CCW_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "second item taken while one is in flight")

endmodule

bind coin_change_way_counter ccw_checker u_ccw_checker (.*);

`default_nettype wire
